/* src/vwt_pkg.sv */
// ----------------------------------------------------------------------------
// Vertex weld table package
// Shared widths and default parameter values for the vertex weld table.
// ----------------------------------------------------------------------------
package vwt_pkg;

    // Default table depth and coordinate width.
    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_COORD_WIDTH  = 24;

    // Fixed field widths on the stream and tolerance ports.
    localparam int FIELD_W   = 24;
    localparam int TOL_W     = 52;
    localparam int IDX_OUT_W = 10;

    // Packed stream widths.
    localparam int IN_DATA_W  = 3 * FIELD_W;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_PAD_W  = OUT_DATA_W - IDX_OUT_W;
    localparam int OUT_USER_W = 2;

    // Tolerance after reset: only exact duplicates weld.
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

endpackage

/* src/vwt_ram.sv */
// ----------------------------------------------------------------------------
// Vertex weld table RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module vwt_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/vwt_dist.sv */
// ----------------------------------------------------------------------------
// Vertex weld distance pipeline
// Three-stage pipeline that forms the squared distance between the probe
// vertex and one stored vertex: axis magnitudes, squares, then their sum.
// ----------------------------------------------------------------------------
module vwt_dist #(
    parameter int COORD_WIDTH = 24,
    parameter int IDX_W       = 10,
    localparam int DW    = COORD_WIDTH + 1,
    localparam int SQW   = 2 * DW,
    localparam int SUM_W = SQW + 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     flush,
    input  logic                     in_valid,
    input  logic [IDX_W-1:0]         in_idx,
    input  logic [3*COORD_WIDTH-1:0] probe,
    input  logic [3*COORD_WIDTH-1:0] entry,
    output logic                     out_valid,
    output logic [IDX_W-1:0]         out_idx,
    output logic [SUM_W-1:0]         out_dist,
    output logic                     busy
);

    // Absolute difference of two signed coordinates, exact in DW bits.
    function automatic logic [DW-1:0] abs_diff(
        input logic [COORD_WIDTH-1:0] a,
        input logic [COORD_WIDTH-1:0] b
    );
        logic signed [DW-1:0] d;
        d = $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
        return d[DW-1] ? DW'(-d) : DW'(d);
    endfunction

    logic             mag_v_reg;
    logic [IDX_W-1:0] mag_idx_reg;
    logic [DW-1:0]    mag_reg [3];
    logic             sq_v_reg;
    logic [IDX_W-1:0] sq_idx_reg;
    logic [SQW-1:0]   sq_reg [3];
    logic             sum_v_reg;
    logic [IDX_W-1:0] sum_idx_reg;
    logic [SUM_W-1:0] sum_reg;

    // Stage valids; a flush drops everything in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_v_reg <= 1'b0;
            sq_v_reg  <= 1'b0;
            sum_v_reg <= 1'b0;
        end
        else
        begin
            mag_v_reg <= in_valid & ~flush;
            sq_v_reg  <= mag_v_reg & ~flush;
            sum_v_reg <= sq_v_reg & ~flush;
        end
    end

    // Datapath: magnitudes, squares, sum of squares.
    always_ff @(posedge clk)
    begin
        mag_idx_reg <= in_idx;
        sq_idx_reg  <= mag_idx_reg;
        sum_idx_reg <= sq_idx_reg;
        for (int a = 0; a < 3; a++)
        begin
            mag_reg[a] <= abs_diff(probe[a*COORD_WIDTH +: COORD_WIDTH],
                                   entry[a*COORD_WIDTH +: COORD_WIDTH]);
            sq_reg[a]  <= SQW'(mag_reg[a]) * SQW'(mag_reg[a]);
        end
        sum_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    end

    assign out_valid = sum_v_reg;
    assign out_idx   = sum_idx_reg;
    assign out_dist  = sum_reg;
    assign busy      = mag_v_reg | sq_v_reg | sum_v_reg;

endmodule

/* src/vertex_weld_table_core.sv */
// ----------------------------------------------------------------------------
// Vertex weld table core
// Welds each mesh vertex within a squared tolerance against a table of unique
// vertices, returning the matching or newly appended index, or overflow.
// ----------------------------------------------------------------------------
// One vertex is handled at a time. Its scan reads the stored vertices from
// the table RAM in insertion order, one entry per cycle, through a
// three-stage distance pipeline, and stops at the first entry whose squared
// distance is below the tolerance. Each read passes the RAM read register and
// the magnitude, square and sum stages. A hit, or the drained pipeline when
// none of the N stored entries matches, sets the result, which waits in
// ST_EMIT until the output register is free. N reaches MAX_VERTICES for a
// full table; an empty table needs no reads. The next vertex can be accepted
// in the cycle after its result is loaded, and the single read port of the
// table RAM sets the scan rate. A result waits in an output register, so the
// next vertex is taken while it is still pending.
module vertex_weld_table_core #(
    parameter int MAX_VERTICES = vwt_pkg::DEF_MAX_VERTICES,
    parameter int COORD_WIDTH  = vwt_pkg::DEF_COORD_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Tolerance register write.
    input  logic                          cfg_wr_en,
    input  logic [vwt_pkg::TOL_W-1:0]     cfg_wr_data,
    // Input vertex stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Fields from bit 0: coord_x[23:0], coord_y[47:24], coord_z[71:48].
    input  logic [vwt_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // Fields from bit 0: first_of_mesh[0].
    input  logic                          s_axis_tuser,
    // Result stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Fields from bit 0: vertex_index[9:0], zero padding[15:10].
    output logic [vwt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: is_new[0], overflow[1].
    output logic [vwt_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int PT_W   = 3 * COORD_WIDTH;
    localparam int SUM_W  = 2 * (COORD_WIDTH + 1) + 2;
    localparam int CMP_W  = (SUM_W > vwt_pkg::TOL_W) ? SUM_W : vwt_pkg::TOL_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_VERTICES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              issue_reg, issue_next;
    logic                          rd_v_reg, rd_v_next;
    logic [ADDR_W-1:0]             rd_idx_reg;
    logic [vwt_pkg::TOL_W-1:0]     tol_reg;
    logic [PT_W-1:0]               probe_reg;
    logic [CNT_W-1:0]              res_idx_reg, res_idx_next;
    logic                          res_new_reg, res_new_next;
    logic                          res_ovf_reg, res_ovf_next;
    logic                          out_valid_reg, out_valid_next;
    logic [vwt_pkg::IDX_OUT_W-1:0] out_idx_reg;
    logic                          out_new_reg;
    logic                          out_ovf_reg;

    logic              in_accept;
    logic              issue;
    logic              hit;
    logic              scan_done;
    logic              out_load;
    logic              ram_wr_en;
    logic [PT_W-1:0]   probe_in;
    logic [PT_W-1:0]   ram_rd_data;
    logic              dist_valid;
    logic [ADDR_W-1:0] dist_idx;
    logic [SUM_W-1:0]  dist_sum;
    logic              dist_busy;

    // Low COORD_WIDTH bits of each axis form the probe vertex.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            probe_in[a*COORD_WIDTH +: COORD_WIDTH] =
                s_axis_tdata[a*vwt_pkg::FIELD_W +: COORD_WIDTH];
        end
    end

    assign in_accept = s_axis_tvalid & s_axis_tready;

    // Scan control: read one entry per cycle until a hit or the count.
    assign hit = dist_valid &&
                 (CMP_W'(dist_sum) < CMP_W'(tol_reg));
    assign issue = (state_reg == ST_SCAN) && (issue_reg != count_reg) && !hit;
    assign scan_done = (state_reg == ST_SCAN) && !hit && (issue_reg == count_reg) &&
                       !rd_v_reg && !dist_busy;
    assign ram_wr_en = scan_done && (count_reg != FULL_COUNT);
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);

    // Next-state and result logic.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        rd_v_next      = issue;
        res_idx_next   = res_idx_reg;
        res_new_next   = res_new_reg;
        res_ovf_next   = res_ovf_reg;
        out_valid_next = out_valid_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    issue_next = '0;
                    if (s_axis_tuser)
                    begin
                        count_next = '0;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                if (hit)
                begin
                    res_idx_next = CNT_W'(dist_idx);
                    res_new_next = 1'b0;
                    res_ovf_next = 1'b0;
                    state_next   = ST_EMIT;
                end
                else if (scan_done)
                begin
                    if (count_reg == FULL_COUNT)
                    begin
                        res_idx_next = '0;
                        res_new_next = 1'b0;
                        res_ovf_next = 1'b1;
                    end
                    else
                    begin
                        res_idx_next = count_reg;
                        res_new_next = 1'b1;
                        res_ovf_next = 1'b0;
                        count_next   = count_reg + 1'b1;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and the registered result beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            rd_v_reg      <= 1'b0;
            tol_reg       <= vwt_pkg::TOL_RESET;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
            out_new_reg   <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            rd_v_reg      <= rd_v_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                tol_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_idx_reg <= vwt_pkg::IDX_OUT_W'(res_idx_reg);
                out_new_reg <= res_new_reg;
                out_ovf_reg <= res_ovf_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= issue_reg[ADDR_W-1:0];
        res_idx_reg <= res_idx_next;
        res_new_reg <= res_new_next;
        res_ovf_reg <= res_ovf_next;
        if (in_accept)
        begin
            probe_reg <= probe_in;
        end
    end

    // Unique vertex table.
    vwt_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_VERTICES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (probe_reg),
        .rd_en   (issue),
        .rd_addr (issue_reg[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // Squared distance pipeline; a hit drops the reads behind it.
    vwt_dist #(
        .COORD_WIDTH (COORD_WIDTH),
        .IDX_W       (ADDR_W)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (hit),
        .in_valid  (rd_v_reg),
        .in_idx    (rd_idx_reg),
        .probe     (probe_reg),
        .entry     (ram_rd_data),
        .out_valid (dist_valid),
        .out_idx   (dist_idx),
        .out_dist  (dist_sum),
        .busy      (dist_busy)
    );

    // Stream outputs.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{vwt_pkg::OUT_PAD_W{1'b0}}, out_idx_reg};
    assign m_axis_tuser  = {out_ovf_reg, out_new_reg};

endmodule
